@@ hw/rtl/cau_pkg.sv @@
`default_nettype none
package cau_pkg;

   localparam int PartWidth = 16;
   localparam int FracBits  = 8;
   // products of two parts and sums of two products
   localparam int ProdWidth = 2 * PartWidth;
   localparam int SumWidth  = ProdWidth + 1;
   // magnitude of a sum of products
   localparam int MagWidth  = ProdWidth + 1;
   // quotient bits: integer part up to the magnitude, then the fraction bits
   localparam int QuotWidth = MagWidth + FracBits;
   // divider cells, one quotient bit each
   localparam int DivCells  = QuotWidth;
   // dividend shifted left for the fraction bits
   localparam int NumWidth  = MagWidth + FracBits;
   // divisor: sum of two squares
   localparam int DenWidth  = ProdWidth + 1;
   // partial remainder carries one bit more than the divisor
   localparam int RemWidth  = DenWidth + 1;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]                   operation;
      logic signed [PartWidth-1:0]  a_real;
      logic signed [PartWidth-1:0]  a_imag;
      logic signed [PartWidth-1:0]  b_real;
      logic signed [PartWidth-1:0]  b_imag;
   } req_type;

   typedef struct packed {
      logic signed [PartWidth-1:0]  result_real;
      logic signed [PartWidth-1:0]  result_imag;
      logic                         divide_by_zero;
      logic                         saturated;
   } rsp_type;

   // one divider lane: dividend bits still to shift in, remainder, quotient so far
   typedef struct packed {
      logic [NumWidth-1:0]  num;
      logic [RemWidth-1:0]  rem;
      logic [QuotWidth-1:0] quot;
   } lane_type;

   // what travels along the cell chain beside the two lanes
   typedef struct packed {
      logic                 vld;
      logic [1:0]           op;
      logic                 neg_re;
      logic                 neg_im;
      logic [MagWidth-1:0]  mag_re;
      logic [MagWidth-1:0]  mag_im;
      logic [DenWidth-1:0]  den;
      logic                 dz;
   } carry_type;

   // clamp sign and magnitude to the signed part range
   function automatic logic [PartWidth:0] clamp_part(input logic neg,
                                                     input logic [QuotWidth-1:0] mag);
      logic [QuotWidth-1:0] pos_lim;
      logic [QuotWidth-1:0] neg_lim;
      logic [PartWidth-1:0] val;
      logic                 sat;
      pos_lim = (QuotWidth'(1) << (PartWidth - 1)) - QuotWidth'(1);
      neg_lim = QuotWidth'(1) << (PartWidth - 1);
      sat = 1'b0;
      if (!neg) begin
         if (mag > pos_lim) begin
            sat = 1'b1;
            val = pos_lim[PartWidth-1:0];
         end else begin
            val = mag[PartWidth-1:0];
         end
      end else begin
         if (mag > neg_lim) begin
            sat = 1'b1;
            val = neg_lim[PartWidth-1:0];
         end else begin
            val = PartWidth'(-mag[PartWidth-1:0]);
         end
      end
      return {sat, val};
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/cau_front.sv @@
`default_nettype none
// two-stage front end: products, then sums turned into sign and magnitude
module cau_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             adv,
   input  wire logic             in_vld,
   input  wire cau_pkg::req_type in_word,
   output cau_pkg::carry_type    out_carry
);

   localparam int PW = cau_pkg::PartWidth;
   localparam int XW = cau_pkg::ProdWidth;
   localparam int SW = cau_pkg::SumWidth;
   localparam int MW = cau_pkg::MagWidth;
   localparam int DW = cau_pkg::DenWidth;

   logic                 s1_vld_ff;
   logic [1:0]           s1_op_ff;
   logic signed [XW-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_bb_ff, p_cc_ff;
   logic signed [PW:0]   add_re_ff, add_im_ff;

   logic signed [XW-1:0] p_rr_in, p_ii_in, p_ri_in, p_ir_in, p_bb_in, p_cc_in;
   logic signed [PW:0]   add_re_in, add_im_in;

   // stage one: six products and the part sums for add and subtract
   always_comb begin
      p_rr_in = XW'(in_word.a_real * in_word.b_real);
      p_ii_in = XW'(in_word.a_imag * in_word.b_imag);
      p_ri_in = XW'(in_word.a_real * in_word.b_imag);
      p_ir_in = XW'(in_word.a_imag * in_word.b_real);
      p_bb_in = XW'(in_word.b_real * in_word.b_real);
      p_cc_in = XW'(in_word.b_imag * in_word.b_imag);
      if (in_word.operation == cau_pkg::OP_SUB) begin
         add_re_in = (PW+1)'(in_word.a_real) - (PW+1)'(in_word.b_real);
         add_im_in = (PW+1)'(in_word.a_imag) - (PW+1)'(in_word.b_imag);
      end else begin
         add_re_in = (PW+1)'(in_word.a_real) + (PW+1)'(in_word.b_real);
         add_im_in = (PW+1)'(in_word.a_imag) + (PW+1)'(in_word.b_imag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_op_ff  <= in_word.operation;
         p_rr_ff   <= p_rr_in;
         p_ii_ff   <= p_ii_in;
         p_ri_ff   <= p_ri_in;
         p_ir_ff   <= p_ir_in;
         p_bb_ff   <= p_bb_in;
         p_cc_ff   <= p_cc_in;
         add_re_ff <= add_re_in;
         add_im_ff <= add_im_in;
      end
   end

   // stage two: sums of products, sign and magnitude, floor shift for multiply
   logic signed [SW-1:0] sum_re, sum_im;
   logic [SW-1:0]        abs_re, abs_im;
   logic                 neg_re, neg_im;
   logic [MW-1:0]        mag_re, mag_im;
   logic [DW-1:0]        den;
   cau_pkg::carry_type   carry_in;
   cau_pkg::carry_type   carry_ff;
   localparam logic [SW-1:0] Round = SW'((64'd1 << cau_pkg::FracBits) - 64'd1);

   always_comb begin
      unique case (cau_pkg::op_type'(s1_op_ff)) inside
         cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
            sum_re = SW'(add_re_ff);
            sum_im = SW'(add_im_ff);
         end
         cau_pkg::OP_MUL: begin
            sum_re = SW'(p_rr_ff) - SW'(p_ii_ff);
            sum_im = SW'(p_ri_ff) + SW'(p_ir_ff);
         end
         default: begin
            sum_re = SW'(p_rr_ff) + SW'(p_ii_ff);
            sum_im = SW'(p_ir_ff) - SW'(p_ri_ff);
         end
      endcase
      neg_re = sum_re[SW-1];
      neg_im = sum_im[SW-1];
      abs_re = neg_re ? SW'(-sum_re) : SW'(sum_re);
      abs_im = neg_im ? SW'(-sum_im) : SW'(sum_im);
      if (s1_op_ff == cau_pkg::OP_MUL) begin
         mag_re = MW'((abs_re + (neg_re ? Round : SW'(0))) >> cau_pkg::FracBits);
         mag_im = MW'((abs_im + (neg_im ? Round : SW'(0))) >> cau_pkg::FracBits);
      end else begin
         mag_re = MW'(abs_re);
         mag_im = MW'(abs_im);
      end
      den = DW'($unsigned(p_bb_ff)) + DW'($unsigned(p_cc_ff));
      carry_in.vld    = s1_vld_ff;
      carry_in.op     = s1_op_ff;
      carry_in.neg_re = neg_re;
      carry_in.neg_im = neg_im;
      carry_in.mag_re = mag_re;
      carry_in.mag_im = mag_im;
      carry_in.den    = den;
      carry_in.dz     = (s1_op_ff == cau_pkg::OP_DIV) && (den == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff.vld <= 1'b0;
      end else if (adv) begin
         carry_ff.vld <= carry_in.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         carry_ff.op     <= carry_in.op;
         carry_ff.neg_re <= carry_in.neg_re;
         carry_ff.neg_im <= carry_in.neg_im;
         carry_ff.mag_re <= carry_in.mag_re;
         carry_ff.mag_im <= carry_in.mag_im;
         carry_ff.den    <= carry_in.den;
         carry_ff.dz     <= carry_in.dz;
      end
   end

   assign out_carry = carry_ff;

endmodule
`default_nettype wire

@@ hw/rtl/cau_div_cell.sv @@
`default_nettype none
// one restoring-division step for both lanes, registered toward the next cell
module cau_div_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               adv,
   input  wire cau_pkg::carry_type in_carry,
   input  wire cau_pkg::lane_type  in_re,
   input  wire cau_pkg::lane_type  in_im,
   output cau_pkg::carry_type      out_carry,
   output cau_pkg::lane_type       out_re,
   output cau_pkg::lane_type       out_im
);

   localparam int NW = cau_pkg::NumWidth;
   localparam int RW = cau_pkg::RemWidth;
   localparam int QW = cau_pkg::QuotWidth;

   cau_pkg::carry_type carry_ff;
   cau_pkg::lane_type  re_ff, re_in;
   cau_pkg::lane_type  im_ff, im_in;

   // shift one dividend bit into the remainder and try the divisor
   function automatic cau_pkg::lane_type step(input cau_pkg::lane_type l,
                                              input logic [RW-1:0] den);
      cau_pkg::lane_type o;
      logic [RW-1:0]     trial;
      trial  = {l.rem[RW-2:0], l.num[NW-1]};
      o.num  = {l.num[NW-2:0], 1'b0};
      if (trial >= den) begin
         o.rem  = trial - den;
         o.quot = {l.quot[QW-2:0], 1'b1};
      end else begin
         o.rem  = trial;
         o.quot = {l.quot[QW-2:0], 1'b0};
      end
      return o;
   endfunction

   always_comb begin
      re_in = step(in_re, RW'(in_carry.den));
      im_in = step(in_im, RW'(in_carry.den));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff.vld <= 1'b0;
      end else if (adv) begin
         carry_ff.vld <= in_carry.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         carry_ff.op     <= in_carry.op;
         carry_ff.neg_re <= in_carry.neg_re;
         carry_ff.neg_im <= in_carry.neg_im;
         carry_ff.mag_re <= in_carry.mag_re;
         carry_ff.mag_im <= in_carry.mag_im;
         carry_ff.den    <= in_carry.den;
         carry_ff.dz     <= in_carry.dz;
         re_ff           <= re_in;
         im_ff           <= im_in;
      end
   end

   assign out_carry = carry_ff;
   assign out_re    = re_ff;
   assign out_im    = im_ff;

endmodule
`default_nettype wire

@@ hw/rtl/complex_arith_unit_core.sv @@
`default_nettype none
// channel | direction | ports
// req     | in        | req_valid, req_ready, req_data (operation, a and b parts)
// rsp     | out       | rsp_valid, rsp_ready, rsp_data (result parts, flags)
//
// one word per cycle while rsp is not stalled; the front end feeds the divider
// chain of one cell per quotient bit (33 integer plus 8 fraction bits)
// every operation runs the full chain so words leave in order
// reset clears the valid bits of all stages; payload registers are not reset
// a stalled rsp freezes the whole pipeline; req_ready follows rsp side room
module complex_arith_unit_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire cau_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output cau_pkg::rsp_type      rsp_data
);

   localparam int NC = cau_pkg::DivCells;
   localparam int NW = cau_pkg::NumWidth;
   localparam int QW = cau_pkg::QuotWidth;

   logic adv;
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   cau_pkg::carry_type carry [NC+1];
   cau_pkg::lane_type  lre   [NC+1];
   cau_pkg::lane_type  lim   [NC+1];

   cau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_vld    (req_valid),
      .in_word   (req_data),
      .out_carry (carry[0])
   );

   // dividend is the magnitude scaled by the fraction bits
   always_comb begin
      lre[0].num  = NW'(carry[0].mag_re) << cau_pkg::FracBits;
      lre[0].rem  = '0;
      lre[0].quot = '0;
      lim[0].num  = NW'(carry[0].mag_im) << cau_pkg::FracBits;
      lim[0].rem  = '0;
      lim[0].quot = '0;
   end

   // chain of division cells
   for (genvar g = 0; g < NC; g++) begin : g_cell
      cau_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_carry  (carry[g]),
         .in_re     (lre[g]),
         .in_im     (lim[g]),
         .out_carry (carry[g+1]),
         .out_re    (lre[g+1]),
         .out_im    (lim[g+1])
      );
   end

   // pick the result, clamp and register the output word
   cau_pkg::carry_type   tail;
   logic [QW-1:0]        res_re, res_im;
   logic [cau_pkg::PartWidth:0] cl_re, cl_im;
   cau_pkg::rsp_type     rsp_in;
   cau_pkg::rsp_type     rsp_ff;
   logic                 rsp_vld_ff;

   always_comb begin
      tail = carry[NC];
      if (tail.op == cau_pkg::OP_DIV) begin
         res_re = lre[NC].quot;
         res_im = lim[NC].quot;
      end else begin
         res_re = QW'(tail.mag_re);
         res_im = QW'(tail.mag_im);
      end
      cl_re = cau_pkg::clamp_part(tail.neg_re, res_re);
      cl_im = cau_pkg::clamp_part(tail.neg_im, res_im);
      if (tail.dz) begin
         rsp_in.result_real    = '0;
         rsp_in.result_imag    = '0;
         rsp_in.divide_by_zero = 1'b1;
         rsp_in.saturated      = 1'b0;
      end else begin
         rsp_in.result_real    = cl_re[cau_pkg::PartWidth-1:0];
         rsp_in.result_imag    = cl_im[cau_pkg::PartWidth-1:0];
         rsp_in.divide_by_zero = 1'b0;
         rsp_in.saturated      = cl_re[cau_pkg::PartWidth] | cl_im[cau_pkg::PartWidth];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= tail.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

@@ hw/rtl/cau_checker.sv @@
`default_nettype none
// port-level checks for the complex unit
module cau_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire cau_pkg::rsp_type rsp_data
);

   // a stalled output word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word changed while stalled");

   // zero divisor never reports saturation and gives zero parts
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.divide_by_zero |->
         !rsp_data.saturated && rsp_data.result_real == '0 && rsp_data.result_imag == '0)
      else $error("divide by zero word not cleared");

   // input side is ready whenever the output side has room
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("req not ready with free output");

   // no output word right after reset without input
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind complex_arith_unit_core cau_checker u_cau_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire
